/* rtl/cfe_pkg.sv */
// cfe_pkg: shared types, widths, latencies and constant tables for the
// cube-face to equirectangular coordinate pipeline. no dependencies.
package cfe_pkg;

    localparam int FRACTION_BITS = 4;
    localparam int CORDIC_STAGES = 16;
    localparam int COORD_BITS    = 24;

    localparam int CFG_W     = 13;
    localparam int NUM_W     = CFG_W + 1;
    localparam int DIV_STEPS = CFG_W + COORD_BITS;
    localparam int COORD_W   = DIV_STEPS + 1;
    localparam int DATA_W    = 44;
    localparam int ANG_W     = 35;
    localparam int WRAP_W    = 33;
    localparam int OUT_W     = 16;
    localparam int GAIN_W    = 27;
    localparam int ATAN_LEN  = 24;

    localparam int DIV_LAT    = DIV_STEPS + 2;
    localparam int CORDIC_LAT = CORDIC_STAGES + 1;
    localparam int SCALE_LAT  = 2;
    localparam int LATENCY    = DIV_LAT + 2 * CORDIC_LAT + SCALE_LAT + 2;

    localparam logic signed [GAIN_W-1:0] GAIN_Q24     = 27'sd27628053;
    localparam logic signed [DATA_W-1:0] COORD_ONE    = 44'sd16777216;
    localparam logic signed [ANG_W-1:0]  QUARTER_TURN = 35'sd1073741824;
    localparam logic signed [ANG_W-1:0]  HALF_TURN    = 35'sd2147483648;
    localparam logic signed [ANG_W-1:0]  FULL_TURN    = 35'sd4294967296;

    localparam logic [2:0] FACE_TOP    = 3'd4;
    localparam logic [2:0] FACE_BOTTOM = 3'd5;

    localparam logic [CFG_W-1:0] FACE_WIDTH_RST     = 13'd512;
    localparam logic [CFG_W-1:0] FACE_HEIGHT_RST    = 13'd512;
    localparam logic [CFG_W-1:0] SOURCE_COLUMNS_RST = 13'd2048;
    localparam logic [CFG_W-1:0] SOURCE_ROWS_RST    = 13'd1024;

    typedef enum logic [1:0] {
        REG_FACE_WIDTH,
        REG_FACE_HEIGHT,
        REG_SOURCE_COLUMNS,
        REG_SOURCE_ROWS
    } cfe_reg_t;

    typedef struct packed {
        logic [2:0]  face_number;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
    } cfe_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] source_u;
        logic [OUT_W-1:0] source_v;
    } cfe_result_t;

    // atan(2^-i), half turn = 2^31
    localparam logic signed [ANG_W-1:0] ATAN_TAB [0:ATAN_LEN-1] = '{
        35'sd536870912, 35'sd316933406, 35'sd167458907, 35'sd85004756,
        35'sd42667331,  35'sd21354465,  35'sd10679838,  35'sd5340245,
        35'sd2670163,   35'sd1335087,   35'sd667544,    35'sd333772,
        35'sd166886,    35'sd83443,     35'sd41722,     35'sd20861,
        35'sd10430,     35'sd5215,      35'sd2608,      35'sd1304,
        35'sd652,       35'sd326,       35'sd163,       35'sd81
    };

    function automatic logic signed [ANG_W-1:0] yaw_offset(input logic [1:0] side);
        logic signed [ANG_W-1:0] yaw;
        case (side)
            2'd0:    yaw = '0;
            2'd1:    yaw = QUARTER_TURN;
            2'd2:    yaw = HALF_TURN;
            default: yaw = -QUARTER_TURN;
        endcase
        return yaw;
    endfunction

endpackage

/* rtl/cube_face_to_equirect_coords.sv */
// cube_face_to_equirect_coords: top level, configuration registers and
// stage alignment. uses cfe_pkg, cfe_div, cfe_cordic and cfe_scale.
//
// usage
//   start/busy: an item (face_number, pixel_x, pixel_y) is taken at a rising
//   edge with start high and busy low. a new item may follow every cycle.
//   done/result: source_u and source_v (unsigned 12.4) show for exactly one
//   cycle with done high, once the item has passed the input register, the
//   37 stage divider (one quotient bit each), the two chained 16 stage
//   cordic pipelines, the wrap register and the scale stages. throughput is
//   one item per cycle while busy is low; results leave in acceptance order.
//   results cannot be held off; done is a strobe only.
//   cfg_valid/cfg_ready: one transaction writes cfg_data into register
//   cfg_index (face_width, face_height, source_columns, source_rows);
//   write only while no item is in flight.
//   reset clears the pipeline and loads the default sizes; busy stays high
//   for the first cycle after reset.
module cube_face_to_equirect_coords
    import cfe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cfe_item_t        item,
    output logic             done,
    output cfe_result_t      result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int FACE_LAT = DIV_LAT + 2 * CORDIC_LAT;
    localparam int SPLIT    = 19;
    localparam int HI_W     = COORD_W - SPLIT;
    localparam int PROD_W   = COORD_W + GAIN_W;
    localparam logic signed [DATA_W-1:0] GAIN_X = DATA_W'(GAIN_Q24);

    logic             busy_reg;
    logic [CFG_W-1:0] face_width_reg;
    logic [CFG_W-1:0] face_height_reg;
    logic [CFG_W-1:0] source_columns_reg;
    logic [CFG_W-1:0] source_rows_reg;
    logic             item_valid_reg;
    cfe_item_t        item_reg;
    logic             accept;

    logic [CFG_W-1:0]        width_div;
    logic [CFG_W-1:0]        height_div;
    logic signed [NUM_W-1:0] num_t;
    logic signed [NUM_W-1:0] num_s;

    logic                      t_valid;
    logic signed [COORD_W-1:0] t_q;
    logic signed [COORD_W-1:0] s_q;
    logic [2:0]                face_pipe_reg [0:FACE_LAT-1];

    logic signed [HI_W+GAIN_W-1:0]  mul_hi_reg;
    logic signed [SPLIT+GAIN_W:0]   mul_lo_reg;
    logic signed [PROD_W-1:0]       mul_sum;
    logic signed [DATA_W-1:0]       sk_pipe_reg [0:CORDIC_LAT-2];

    logic [2:0]               face_div;
    logic                     pole_div;
    logic signed [DATA_W-1:0] t_ext;
    logic signed [DATA_W-1:0] s_ext;
    logic signed [DATA_W-1:0] c1_x;
    logic signed [DATA_W-1:0] c1_y;
    logic                     c1_valid;
    logic signed [ANG_W-1:0]  c1_angle;
    logic signed [DATA_W-1:0] c1_mag;

    logic [2:0]               face_c1;
    logic                     pole_c1;
    logic signed [ANG_W-1:0]  u_c1;
    logic signed [ANG_W-1:0]  u_pipe_reg [0:CORDIC_LAT-1];
    logic signed [DATA_W-1:0] c2_x;
    logic signed [DATA_W-1:0] c2_y;
    logic                     c2_valid;
    logic signed [ANG_W-1:0]  c2_angle;

    logic [2:0]               face_c2;
    logic signed [ANG_W-1:0]  a2_dbl;
    logic signed [ANG_W-1:0]  v_raw;
    logic signed [ANG_W-1:0]  u_raw;
    logic signed [ANG_W-1:0]  u_wrap;
    logic signed [ANG_W-1:0]  u_clamp;
    logic signed [ANG_W-1:0]  v_clamp;
    logic                     wrap_valid_reg;
    logic signed [WRAP_W-1:0] wrap_u_reg;
    logic signed [WRAP_W-1:0] wrap_v_reg;

    assign accept    = start && !busy_reg;
    assign busy      = busy_reg;
    assign cfg_ready = !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg           <= 1'b1;
            item_valid_reg     <= 1'b0;
            face_width_reg     <= FACE_WIDTH_RST;
            face_height_reg    <= FACE_HEIGHT_RST;
            source_columns_reg <= SOURCE_COLUMNS_RST;
            source_rows_reg    <= SOURCE_ROWS_RST;
        end
        else
        begin
            busy_reg       <= 1'b0;
            item_valid_reg <= accept;
            if (cfg_valid && cfg_ready)
            begin
                case (cfe_reg_t'(cfg_index))
                    REG_FACE_WIDTH:     face_width_reg     <= cfg_data;
                    REG_FACE_HEIGHT:    face_height_reg    <= cfg_data;
                    REG_SOURCE_COLUMNS: source_columns_reg <= cfg_data;
                    REG_SOURCE_ROWS:    source_rows_reg    <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

    // zero face size acts as one
    assign width_div  = (face_width_reg == '0) ? CFG_W'(1) : face_width_reg;
    assign height_div = (face_height_reg == '0) ? CFG_W'(1) : face_height_reg;
    assign num_t = $signed({1'b0, item_reg.pixel_y, 1'b0}) - $signed({1'b0, height_div});
    assign num_s = $signed({1'b0, item_reg.pixel_x, 1'b0}) - $signed({1'b0, width_div});

    cfe_div u_div_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_valid_reg),
        .num       (num_t),
        .divisor   (height_div),
        .out_valid (t_valid),
        .quotient  (t_q)
    );

    cfe_div u_div_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_valid_reg),
        .num       (num_s),
        .divisor   (width_div),
        .out_valid (),
        .quotient  (s_q)
    );

    always_ff @(posedge clk)
    begin
        face_pipe_reg[0] <= item_reg.face_number;
        for (int k = 1; k < FACE_LAT; k++)
        begin
            face_pipe_reg[k] <= face_pipe_reg[k-1];
        end
    end

    // s times cordic gain, split in two partial products
    assign mul_sum = (PROD_W'(mul_hi_reg) <<< SPLIT) + PROD_W'(mul_lo_reg);

    always_ff @(posedge clk)
    begin
        mul_hi_reg     <= $signed(s_q[COORD_W-1:SPLIT]) * GAIN_Q24;
        mul_lo_reg     <= $signed({1'b0, s_q[SPLIT-1:0]}) * GAIN_Q24;
        sk_pipe_reg[0] <= DATA_W'(mul_sum >>> COORD_BITS);
        for (int k = 1; k < CORDIC_LAT - 1; k++)
        begin
            sk_pipe_reg[k] <= sk_pipe_reg[k-1];
        end
    end

    assign face_div = face_pipe_reg[DIV_LAT-1];
    assign pole_div = (face_div == FACE_TOP) || (face_div == FACE_BOTTOM);
    assign t_ext    = DATA_W'(t_q);
    assign s_ext    = DATA_W'(s_q);
    assign c1_x     = pole_div ? t_ext : COORD_ONE;
    assign c1_y     = pole_div ? ((face_div == FACE_BOTTOM) ? s_ext : -s_ext) : t_ext;

    cfe_cordic u_cordic_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t_valid),
        .x_in      (c1_x),
        .y_in      (c1_y),
        .out_valid (c1_valid),
        .angle     (c1_angle),
        .magnitude (c1_mag)
    );

    assign face_c1 = face_pipe_reg[DIV_LAT+CORDIC_LAT-1];
    assign pole_c1 = (face_c1 == FACE_TOP) || (face_c1 == FACE_BOTTOM);
    assign u_c1    = pole_c1 ? c1_angle : c1_angle + yaw_offset(face_c1[1:0]);
    assign c2_x    = pole_c1 ? GAIN_X : c1_mag;
    assign c2_y    = pole_c1 ? c1_mag : sk_pipe_reg[CORDIC_LAT-2];

    always_ff @(posedge clk)
    begin
        u_pipe_reg[0] <= u_c1;
        for (int k = 1; k < CORDIC_LAT; k++)
        begin
            u_pipe_reg[k] <= u_pipe_reg[k-1];
        end
    end

    cfe_cordic u_cordic_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c1_valid),
        .x_in      (c2_x),
        .y_in      (c2_y),
        .out_valid (c2_valid),
        .angle     (c2_angle),
        .magnitude ()
    );

    assign face_c2 = face_pipe_reg[FACE_LAT-1];
    assign a2_dbl  = c2_angle <<< 1;
    assign u_raw   = u_pipe_reg[CORDIC_LAT-1];

    always_comb
    begin
        case (face_c2)
            FACE_TOP:    v_raw = a2_dbl - HALF_TURN;
            FACE_BOTTOM: v_raw = HALF_TURN - a2_dbl;
            default:     v_raw = a2_dbl;
        endcase
        if (u_raw > HALF_TURN)
        begin
            u_wrap = u_raw - FULL_TURN;
        end
        else if (u_raw < -HALF_TURN)
        begin
            u_wrap = u_raw + FULL_TURN;
        end
        else
        begin
            u_wrap = u_raw;
        end
        u_clamp = u_wrap;
        if (u_wrap > HALF_TURN)
        begin
            u_clamp = HALF_TURN;
        end
        if (u_wrap < -HALF_TURN)
        begin
            u_clamp = -HALF_TURN;
        end
        v_clamp = v_raw;
        if (v_raw > HALF_TURN)
        begin
            v_clamp = HALF_TURN;
        end
        if (v_raw < -HALF_TURN)
        begin
            v_clamp = -HALF_TURN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_valid_reg <= 1'b0;
        end
        else
        begin
            wrap_valid_reg <= c2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        wrap_u_reg <= WRAP_W'(u_clamp);
        wrap_v_reg <= WRAP_W'(v_clamp);
    end

    cfe_scale u_scale_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (wrap_valid_reg),
        .angle     (wrap_u_reg),
        .size      (source_columns_reg),
        .out_valid (done),
        .coord     (result.source_u)
    );

    cfe_scale u_scale_v (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (wrap_valid_reg),
        .angle     (wrap_v_reg),
        .size      (source_rows_reg),
        .out_valid (),
        .coord     (result.source_v)
    );

endmodule

/* rtl/cfe_div.sv */
// cfe_div: pipelined restoring divider, one quotient bit per stage,
// gives (num * 2^COORD_BITS) / divisor truncated toward zero. uses cfe_pkg.
module cfe_div
    import cfe_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic signed [NUM_W-1:0]   num,
    input  logic [CFG_W-1:0]          divisor,
    output logic                      out_valid,
    output logic signed [COORD_W-1:0] quotient
);

    logic                 valid_reg [0:DIV_STEPS];
    logic                 neg_reg   [0:DIV_STEPS];
    logic [CFG_W-1:0]     dvd_reg   [0:DIV_STEPS];
    logic [CFG_W-1:0]     rem_reg   [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] quo_reg   [0:DIV_STEPS];
    logic [CFG_W-1:0]     rem_next  [0:DIV_STEPS-1];
    logic                 fits      [0:DIV_STEPS-1];
    logic [NUM_W-1:0]     abs_num;
    logic                 out_valid_reg;
    logic signed [COORD_W-1:0] quotient_reg;

    assign abs_num = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

    always_comb
    begin
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            fits[k] = {rem_reg[k], dvd_reg[k][CFG_W-1]} >= {1'b0, divisor};
            if (fits[k])
            begin
                rem_next[k] = CFG_W'({rem_reg[k], dvd_reg[k][CFG_W-1]} - {1'b0, divisor});
            end
            else
            begin
                rem_next[k] = {rem_reg[k][CFG_W-2:0], dvd_reg[k][CFG_W-1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
            out_valid_reg <= valid_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg[0] <= num[NUM_W-1];
        dvd_reg[0] <= abs_num[CFG_W-1:0];
        rem_reg[0] <= '0;
        quo_reg[0] <= '0;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            neg_reg[k+1] <= neg_reg[k];
            dvd_reg[k+1] <= {dvd_reg[k][CFG_W-2:0], 1'b0};
            rem_reg[k+1] <= rem_next[k];
            quo_reg[k+1] <= {quo_reg[k][DIV_STEPS-2:0], fits[k]};
        end
        if (neg_reg[DIV_STEPS])
        begin
            quotient_reg <= -$signed({1'b0, quo_reg[DIV_STEPS]});
        end
        else
        begin
            quotient_reg <= $signed({1'b0, quo_reg[DIV_STEPS]});
        end
    end

    assign out_valid = out_valid_reg;
    assign quotient  = quotient_reg;

endmodule

/* rtl/cfe_cordic.sv */
// cfe_cordic: pipelined cordic vectoring, one micro-rotation per stage,
// gives the angle of (x, y) and the gain-scaled magnitude. uses cfe_pkg.
module cfe_cordic
    import cfe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic signed [DATA_W-1:0] x_in,
    input  logic signed [DATA_W-1:0] y_in,
    output logic                     out_valid,
    output logic signed [ANG_W-1:0]  angle,
    output logic signed [DATA_W-1:0] magnitude
);

    logic                     valid_reg [0:CORDIC_STAGES];
    logic                     zero_reg  [0:CORDIC_STAGES];
    logic signed [DATA_W-1:0] x_reg     [0:CORDIC_STAGES];
    logic signed [DATA_W-1:0] y_reg     [0:CORDIC_STAGES];
    logic signed [ANG_W-1:0]  z_reg     [0:CORDIC_STAGES];
    logic signed [DATA_W-1:0] x_next    [1:CORDIC_STAGES];
    logic signed [DATA_W-1:0] y_next    [1:CORDIC_STAGES];
    logic signed [ANG_W-1:0]  z_next    [1:CORDIC_STAGES];
    logic signed [DATA_W-1:0] x_pre;
    logic signed [DATA_W-1:0] y_pre;
    logic signed [ANG_W-1:0]  z_pre;

    // left half plane rotated by a quarter turn first
    always_comb
    begin
        x_pre = x_in;
        y_pre = y_in;
        z_pre = '0;
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                x_pre = y_in;
                y_pre = -x_in;
                z_pre = QUARTER_TURN;
            end
            else
            begin
                x_pre = -y_in;
                y_pre = x_in;
                z_pre = -QUARTER_TURN;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            if (y_reg[i] >= 0)
            begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] + ATAN_TAB[i];
            end
            else
            begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] - ATAN_TAB[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= CORDIC_STAGES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg[0] <= (x_in == 0) && (y_in == 0);
        x_reg[0]    <= x_pre;
        y_reg[0]    <= y_pre;
        z_reg[0]    <= z_pre;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            zero_reg[i+1] <= zero_reg[i];
            x_reg[i+1]    <= x_next[i+1];
            y_reg[i+1]    <= y_next[i+1];
            z_reg[i+1]    <= z_next[i+1];
        end
    end

    assign out_valid = valid_reg[CORDIC_STAGES];
    assign angle     = zero_reg[CORDIC_STAGES] ? '0 : z_reg[CORDIC_STAGES];
    assign magnitude = zero_reg[CORDIC_STAGES] ? '0 : x_reg[CORDIC_STAGES];

endmodule

/* rtl/cfe_scale.sv */
// cfe_scale: maps a wrapped angle onto a panorama axis in fixed point,
// multiply stage then round and saturate stage. uses cfe_pkg.
module cfe_scale
    import cfe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic signed [WRAP_W-1:0] angle,
    input  logic [CFG_W-1:0]         size,
    output logic                     out_valid,
    output logic [OUT_W-1:0]         coord
);

    localparam int PROD_W = WRAP_W + CFG_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SHIFT  = 32 - FRACTION_BITS;
    localparam logic [WRAP_W-1:0] POS_OFFSET = WRAP_W'(1) << 31;
    localparam logic [SUM_W-1:0]  ROUND_HALF = SUM_W'(1) << (SHIFT - 1);

    logic [WRAP_W-1:0] pos;
    logic [CFG_W-1:0]  span;
    logic [SUM_W-1:0]  rounded;
    logic [SUM_W-1:0]  quo;
    logic [PROD_W-1:0] prod_reg;
    logic              prod_valid_reg;
    logic [OUT_W-1:0]  coord_reg;
    logic              out_valid_reg;

    assign pos     = $unsigned(angle) + POS_OFFSET;
    assign span    = (size >= CFG_W'(2)) ? CFG_W'(size - 1'b1) : '0;
    assign rounded = {1'b0, prod_reg} + ROUND_HALF;
    assign quo     = rounded >> SHIFT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
            out_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(pos) * PROD_W'(span);
        if (|quo[SUM_W-1:OUT_W])
        begin
            coord_reg <= '1;
        end
        else
        begin
            coord_reg <= quo[OUT_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign coord     = coord_reg;

endmodule

/* rtl/cfe_checker.sv */
// cfe_checker: port-level checks for cube_face_to_equirect_coords and the
// bind that attaches them. uses cfe_pkg.
module cfe_checker
    import cfe_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // every accepted transaction comes out after the fixed latency
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted item produced no result");

    // no result without a transaction accepted exactly the latency before
    a_done_caused: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching item");

    // busy only in the first cycle out of reset
    a_busy_short: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> !busy)
        else $error("busy after startup");

endmodule

bind cube_face_to_equirect_coords cfe_checker u_cfe_checker (.*);
